[rtl/hcs_pkg.sv]
`timescale 1ns / 1ps
package hcs_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_STAMP = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_DEPTH  = 2'd1;

  typedef struct packed {
    logic        start;
    logic [1:0]  action;
    logic        pos_init;
    logic        pos_step;
    logic        mem_rd;
    logic        calc_start;
    logic        mem_wr;
    logic        load_out;
  } cmd_t;

  typedef struct packed {
    logic        last_pos;
    logic        calc_done;
    logic        radius_zero;
  } sts_t;

endpackage

[rtl/hcs_if.sv]
`timescale 1ns / 1ps
interface hcs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [7:0] cell_x;
  logic signed [7:0] cell_z;
  logic signed [23:0] write_height;
  modport source (output valid, action, cell_x, cell_z, write_height, input ready);
  modport sink (input valid, action, cell_x, cell_z, write_height, output ready);
endinterface

interface hcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] read_height;
  logic               outside_grid;
  modport source (output valid, read_height, outside_grid, input ready);
  modport sink (input valid, read_height, outside_grid, output ready);
endinterface

[rtl/hcs_ctrl.sv]
`timescale 1ns / 1ps
module hcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_action,
  output logic           out_valid,
  input  logic           out_ready,
  output hcs_pkg::cmd_t  cmd,
  input  hcs_pkg::sts_t  sts
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CALC = 7'b0000100,
    S_WAIT = 7'b0001000,
    S_WR   = 7'b0010000,
    S_DONE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] act;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act <= hcs_pkg::ACT_NONE;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        act <= in_action;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.action = act;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cmd.action = in_action;
          cmd.pos_init = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (act == hcs_pkg::ACT_STAMP && sts.radius_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (act != hcs_pkg::ACT_STAMP || sts.calc_done) begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        if (act == hcs_pkg::ACT_STAMP && !sts.last_pos) begin
          cmd.pos_step = 1'b1;
          state_next = S_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.load_out = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_ready_out: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");

endmodule

[rtl/hcs_depth.sv]
`timescale 1ns / 1ps
// Sequential bowl depth: bitwise search for round(65536*d^3/r^3), then weight scale.
module hcs_depth (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [11:0] d2,
  input  logic [5:0]  r,
  input  logic [22:0] max_depth,
  output logic        done,
  output logic [23:0] depth
);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_PREP = 5'b00010,
    D_SRCH = 5'b00100,
    D_MUL  = 5'b01000,
    D_FIN  = 5'b10000
  } dstate_t;

  dstate_t     st;
  logic [35:0] d3;
  logic [17:0] r3;
  logic [23:0] d2sq;
  logic [16:0] q;
  logic [4:0]  bitn;
  logic [40:0] prod;
  logic [16:0] trial;
  logic [34:0] qr;
  logic [34:0] step;
  logic [34:0] x;
  logic [69:0] xsq;
  logic [69:0] lim;

  // The register qr holds 2*q*r^3, so (2*trial-1)*r^3 needs only an add and a subtract.
  assign trial = q | (17'd1 << bitn);
  assign step = 35'(r3) << (bitn + 5'd1);
  assign x = qr + step - 35'(r3);
  assign xsq = 70'(x) * 70'(x);
  assign lim = {d3, 34'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        D_IDLE: begin
          if (start) begin
            d2sq <= 24'(d2) * 24'(d2);
            r3 <= 18'(12'(r) * 12'(r)) * 18'(r);
            q <= '0;
            qr <= '0;
            bitn <= 5'd16;
            st <= D_PREP;
          end
        end
        D_PREP: begin
          d3 <= 36'(d2sq) * 36'(d2);
          st <= D_SRCH;
        end
        D_SRCH: begin
          if (trial <= 17'd65536 && xsq <= lim) begin
            q <= trial;
            qr <= qr + step;
          end
          if (bitn == 5'd0) begin
            st <= D_MUL;
          end else begin
            bitn <= bitn - 5'd1;
          end
        end
        D_MUL: begin
          prod <= 41'(max_depth) * (41'd65536 - 41'(q)) + 41'd32768;
          st <= D_FIN;
        end
        D_FIN: begin
          depth <= 24'd0 - {1'b0, prod[38:16]};
          done <= 1'b1;
          st <= D_IDLE;
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule

[rtl/hcs_datapath.sv]
`timescale 1ns / 1ps
module hcs_datapath #(
  parameter int GRID_SIZE  = 129,
  parameter int MAX_RADIUS = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  hcs_pkg::cmd_t      cmd,
  output hcs_pkg::sts_t      sts,
  input  logic signed [7:0]  cell_x,
  input  logic signed [7:0]  cell_z,
  input  logic signed [23:0] write_height,
  input  logic [4:0]         stamp_radius,
  input  logic [22:0]        max_depth,
  output logic signed [23:0] read_height,
  output logic               outside_grid
);

  localparam int HALF  = GRID_SIZE / 2;
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);

  logic signed [23:0] mem [DEPTH];
  logic signed [8:0]  cx, cz;
  logic signed [RW+1:0] ox, oz;
  logic [RW-1:0]      r;
  logic signed [23:0] wh;
  logic signed [23:0] rd_data;
  logic [AW-1:0]      addr;
  logic               in_grid, in_circ, flag, ok;
  logic signed [10:0] px, pz;
  logic [11:0]        d2, rr;
  logic [23:0]        depth;
  logic               calc_done;
  logic [RW-1:0]      r_sat;

  assign r_sat = (32'(stamp_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(stamp_radius);
  assign px = 11'(cx) + 11'(ox) + 11'(HALF);
  assign pz = 11'(cz) + 11'(oz) + 11'(HALF);
  assign in_grid = px >= 0 && px < 11'(GRID_SIZE) && pz >= 0 && pz < 11'(GRID_SIZE);
  assign d2 = 12'(ox * ox) + 12'(oz * oz);
  assign rr = 12'(r) * 12'(r);
  assign in_circ = d2 <= rr;
  assign sts.last_pos = (ox == (RW+2)'(r)) && (oz == (RW+2)'(r));
  assign sts.radius_zero = (r == '0);
  assign sts.calc_done = calc_done;

  hcs_depth u_depth (
    .clk(clk), .rst(rst), .start(cmd.calc_start && cmd.action == hcs_pkg::ACT_STAMP),
    .d2(d2), .r(6'(r)), .max_depth(max_depth), .done(calc_done), .depth(depth)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx <= 9'(cell_x);
      cz <= 9'(cell_z);
      wh <= write_height;
      r <= r_sat;
      flag <= 1'b0;
    end
    if (cmd.pos_init) begin
      if (cmd.action == hcs_pkg::ACT_STAMP) begin
        ox <= -(RW+2)'(r_sat);
        oz <= -(RW+2)'(r_sat);
      end else begin
        ox <= '0;
        oz <= '0;
      end
    end
    if (cmd.pos_step) begin
      if (oz == (RW+2)'(r)) begin
        oz <= -(RW+2)'(r);
        ox <= ox + 1'b1;
      end else begin
        oz <= oz + 1'b1;
      end
    end
    if (cmd.mem_rd) begin
      addr <= AW'(px) * AW'(GRID_SIZE) + AW'(pz);
      ok <= in_grid && (cmd.action != hcs_pkg::ACT_STAMP || in_circ);
      if (!in_grid && (cmd.action != hcs_pkg::ACT_STAMP || in_circ)) begin
        flag <= 1'b1;
      end
    end
    if (cmd.calc_start) begin
      rd_data <= mem[addr];
    end
    if (cmd.mem_wr && ok) begin
      if (cmd.action == hcs_pkg::ACT_WRITE) begin
        mem[addr] <= wh;
      end else if (cmd.action == hcs_pkg::ACT_STAMP && $signed(depth) < rd_data) begin
        mem[addr] <= depth;
      end
    end
    if (cmd.load_out) begin
      outside_grid <= (cmd.action == hcs_pkg::ACT_NONE) ? 1'b0 : flag;
      read_height <= (cmd.action == hcs_pkg::ACT_READ && !flag) ? rd_data : '0;
    end
  end

endmodule

[rtl/heightmap_circle_stamp_unit.sv]
`timescale 1ns / 1ps
// Height grid with write, read and circular min-blend stamp actions. Each item
// returns one result. Write and read pass through the read, calc, wait, write,
// done and output states; a stamp walks the (2r+1) square one offset at a time,
// and for each offset the bowl depth comes from a bit-serial 17-step rounding
// search in the depth unit, followed by a read-modify-write of the single-port
// store. A stamp with radius zero goes from the read state straight to done.
module heightmap_circle_stamp_unit #(
  parameter int GRID_SIZE  = 129,
  parameter int MAX_RADIUS = 31
) (
  input  logic        clk,
  input  logic        rst,
  hcs_in_if.sink      in_ch,
  hcs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  hcs_pkg::cmd_t cmd;
  hcs_pkg::sts_t sts;
  logic [4:0]    stamp_radius;
  logic [22:0]   max_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_radius <= 5'd8;
      max_depth <= 23'd512;
    end else if (cfg_we) begin
      if (cfg_index == hcs_pkg::CFG_RADIUS) begin
        stamp_radius <= cfg_data[4:0];
      end else if (cfg_index == hcs_pkg::CFG_DEPTH) begin
        max_depth <= cfg_data;
      end
    end
  end

  hcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.action), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  hcs_datapath #(.GRID_SIZE(GRID_SIZE), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cell_x(in_ch.cell_x),
    .cell_z(in_ch.cell_z), .write_height(in_ch.write_height),
    .stamp_radius(stamp_radius), .max_depth(max_depth),
    .read_height(out_ch.read_height), .outside_grid(out_ch.outside_grid)
  );

endmodule

[test/tb_heightmap_circle_stamp_unit.sv]
`timescale 1ns / 1ps
module tb_heightmap_circle_stamp_unit;

  localparam int GRID = 129;
  localparam int HALF = GRID / 2;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic signed [23:0] height;
    logic               flag;
  } answer_t;

  class height_scoreboard;
    logic signed [23:0] heights [GRID * GRID];
    bit                 filled [GRID * GRID];
    bit [4:0]           radius;
    bit [22:0]          bowl_max;
    answer_t            awaited [$];
    int                 errors;
    int                 flagged;
    int                 checked;

    function new();
      radius = 5'd8;
      bowl_max = 23'd512;
    endfunction

    function bit on_grid(int c);
      return c + HALF >= 0 && c + HALF < GRID;
    endfunction

    function int slot(int x, int z);
      return (x + HALF) * GRID + (z + HALF);
    endfunction

    function void set_reg(logic [1:0] index, logic [22:0] value);
      if (index == hcs_pkg::CFG_RADIUS) radius = value[4:0];
      else if (index == hcs_pkg::CFG_DEPTH) bowl_max = value;
    endfunction

    // Nearest Q1.16 value of (d/r)^3, ties rounding up, by exact integer search.
    function int cube_q16(int d2, int r);
      bit [127:0] r6, d6, lhs;
      int lo, hi, mid;
      r6 = 128'(r) * r * r * r * r * r;
      d6 = (128'(d2) * d2 * d2) << 34;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 128'(2 * mid - 1);
        lhs = lhs * lhs * r6;
        if (lhs <= d6) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function logic signed [23:0] bowl(int d2, int r);
      bit [63:0] p;
      p = (64'(bowl_max) * 64'(65536 - cube_q16(d2, r)) + 64'd32768) >> 16;
      return -$signed(24'(p));
    endfunction

    function bit stamp(int cx, int cz);
      int r, d2, idx;
      bit flag;
      logic signed [23:0] depth;
      r = radius;
      flag = 0;
      if (r == 0) return 0;
      for (int dx = -r; dx <= r; dx++) begin
        for (int dz = -r; dz <= r; dz++) begin
          d2 = dx * dx + dz * dz;
          if (d2 > r * r) continue;
          if (!on_grid(cx + dx) || !on_grid(cz + dz)) begin
            flag = 1;
            continue;
          end
          idx = slot(cx + dx, cz + dz);
          depth = bowl(d2, r);
          if (depth < heights[idx]) heights[idx] = depth;
        end
      end
      return flag;
    endfunction

    function void note_input(hcs_pkg::action_t a, int x, int z, logic signed [23:0] h);
      answer_t e;
      bit on_map;
      e.height = '0;
      e.flag = 0;
      on_map = on_grid(x) && on_grid(z);
      case (a)
        hcs_pkg::ACT_WRITE: begin
          if (on_map) begin
            heights[slot(x, z)] = h;
            filled[slot(x, z)] = 1;
          end else e.flag = 1;
        end
        hcs_pkg::ACT_READ: begin
          if (on_map) e.height = heights[slot(x, z)];
          else e.flag = 1;
        end
        hcs_pkg::ACT_STAMP: e.flag = stamp(x, z);
        default: ;
      endcase
      awaited = {awaited, e};
    endfunction

    function void check(logic signed [23:0] height, logic flag);
      answer_t e;
      checked++;
      if (awaited.size() == 0) begin
        $error("result with no pending expectation: read_height %0d outside_grid %0b",
               height, flag);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (flag === 1'b1) flagged++;
      if (height !== e.height) begin
        $error("read_height: expected %0d, actual %0d", e.height, height);
        errors++;
      end
      if (flag !== e.flag) begin
        $error("outside_grid: expected %0b, actual %0b", e.flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;
  bit calm = 0;
  int cycles = 0;
  int n_write = 0, n_read = 0, n_stamp = 0, n_none = 0;
  int seen_x [$];
  int seen_z [$];
  height_scoreboard sb;

  hcs_in_if in_ch ();
  hcs_out_if out_ch ();

  heightmap_circle_stamp_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.action = '0;
    in_ch.cell_x = '0;
    in_ch.cell_z = '0;
    in_ch.write_height = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_heightmap_circle_stamp_unit: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check(out_ch.read_height, out_ch.outside_grid);
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);
  end

  task automatic put(hcs_pkg::action_t a, int x, int z, logic signed [23:0] h);
    if (!calm && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.action <= a;
    in_ch.cell_x <= 8'(x);
    in_ch.cell_z <= 8'(z);
    in_ch.write_height <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(a, x, z, h);
    case (a)
      hcs_pkg::ACT_WRITE: begin
        n_write++;
        if (sb.on_grid(x) && sb.on_grid(z)) begin
          seen_x = {seen_x, x};
          seen_z = {seen_z, z};
        end
      end
      hcs_pkg::ACT_READ: n_read++;
      hcs_pkg::ACT_STAMP: n_stamp++;
      default: n_none++;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] index, logic [22:0] value);
    drain();
    cfg_we <= 1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(index, value);
  endtask

  function automatic logic signed [23:0] any_height();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
      2: return -$signed(24'($urandom_range(0, 2 * sb.bowl_max + 2)));
      default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  // Fill every unwritten in-grid cell the next stamp at (cx, cz) will visit.
  task automatic prepare(int cx, int cz);
    int r;
    r = sb.radius;
    for (int dx = -r; dx <= r; dx++) begin
      for (int dz = -r; dz <= r; dz++) begin
        if (dx * dx + dz * dz > r * r) continue;
        if (!sb.on_grid(cx + dx) || !sb.on_grid(cz + dz)) continue;
        if (!sb.filled[sb.slot(cx + dx, cz + dz)]) begin
          put(hcs_pkg::ACT_WRITE, cx + dx, cz + dz, any_height());
        end
      end
    end
  endtask

  task automatic stamp_at(int cx, int cz);
    prepare(cx, cz);
    put(hcs_pkg::ACT_STAMP, cx, cz, 24'($urandom));
  endtask

  task automatic read_somewhere();
    int k, x, z;
    if (seen_x.size() > 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, seen_x.size() - 1);
      put(hcs_pkg::ACT_READ, seen_x[k], seen_z[k], 24'($urandom));
    end else begin
      do begin
        x = $signed(8'($urandom));
        z = $signed(8'($urandom));
      end while (sb.on_grid(x) && sb.on_grid(z));
      put(hcs_pkg::ACT_READ, x, z, 24'($urandom));
    end
  endtask

  task automatic random_items(int count);
    int spot_x [6] = '{0, -64, 64, -64, 63, 10};
    int spot_z [6] = '{0, -64, 64, 60, -62, -30};
    int pick, k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) == 0) drain();
      if (pick < 30) begin
        k = $urandom_range(0, 5);
        put(hcs_pkg::ACT_WRITE, spot_x[k] + $urandom_range(0, 8) - 4,
            spot_z[k] + $urandom_range(0, 8) - 4, any_height());
      end else if (pick < 45) begin
        read_somewhere();
      end else if (pick < 80) begin
        k = $urandom_range(0, 5);
        stamp_at(spot_x[k] + $urandom_range(0, 6) - 3, spot_z[k] + $urandom_range(0, 6) - 3);
      end else if (pick < 92) begin
        put(hcs_pkg::ACT_WRITE, $signed(8'($urandom)), $signed(8'($urandom)), any_height());
      end else begin
        put(hcs_pkg::ACT_NONE, $signed(8'($urandom)), $signed(8'($urandom)), 24'($urandom));
      end
    end
  endtask

  initial begin
    int radii [7] = '{2, 1, 3, 4, 0, 5, 3};
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    put(hcs_pkg::ACT_WRITE, -64, -64, 24'sh800000);
    put(hcs_pkg::ACT_WRITE, 64, 64, 24'sh7FFFFF);
    put(hcs_pkg::ACT_WRITE, 0, 0, 24'sd0);
    put(hcs_pkg::ACT_WRITE, 127, 0, 24'sh7FFFFF);
    put(hcs_pkg::ACT_WRITE, 0, -128, 24'sh800000);
    put(hcs_pkg::ACT_WRITE, -65, 65, 24'sd1);
    put(hcs_pkg::ACT_READ, -64, -64, '0);
    put(hcs_pkg::ACT_READ, 64, 64, '0);
    put(hcs_pkg::ACT_READ, 0, 0, 24'hFFFFFF);
    put(hcs_pkg::ACT_READ, -128, 127, '0);
    put(hcs_pkg::ACT_READ, 65, -65, '0);
    put(hcs_pkg::ACT_NONE, -1, -1, 24'hFFFFFF);
    put(hcs_pkg::ACT_NONE, 0, 0, '0);
    stamp_at(64, 64);
    put(hcs_pkg::ACT_READ, 64, 64, '0);
    stamp_at(62, 50);
    put(hcs_pkg::ACT_READ, 62, 50, '0);

    set_reg(hcs_pkg::CFG_RADIUS, 23'd31);
    set_reg(hcs_pkg::CFG_DEPTH, 23'h7FFFFF);
    stamp_at(-84, -84);
    put(hcs_pkg::ACT_READ, -64, -64, '0);
    put(hcs_pkg::ACT_READ, -63, -62, '0);
    set_reg(hcs_pkg::CFG_RADIUS, 23'd0);
    put(hcs_pkg::ACT_STAMP, 0, 0, '0);
    put(hcs_pkg::ACT_STAMP, -128, 127, '0);

    for (int p = 0; p < 7; p++) begin
      set_reg(hcs_pkg::CFG_RADIUS, 23'(radii[p]));
      case (p % 4)
        0: set_reg(hcs_pkg::CFG_DEPTH, 23'($urandom));
        1: set_reg(hcs_pkg::CFG_DEPTH, 23'd0);
        2: set_reg(hcs_pkg::CFG_DEPTH, 23'h7FFFFF);
        default: set_reg(hcs_pkg::CFG_DEPTH, 23'($urandom_range(1, 4096)));
      endcase
      calm = (p == 2);
      random_items(60);
    end
    calm = 0;

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d writes, %0d reads, %0d stamps and %0d idle actions across several radius and depth settings.",
             n_write, n_read, n_stamp, n_none);
    $display("Checked %0d results, %0d of them flagged outside the grid.", sb.checked, sb.flagged);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb_heightmap_circle_stamp_unit: PASS");
    end else begin
      $display("tb_heightmap_circle_stamp_unit: FAIL");
    end
    $finish;
  end

endmodule
